FILE: rtl/efpk_pkg.sv
package efpk_pkg;

   // Field widths
   localparam int KEY_W   = 8;
   localparam int COUNT_W = 12;
   localparam int SPEED_W = 5;

   // Kept bytes per buffer, default
   localparam int BUFFER_LIMIT_DEFAULT = 2048;

   // Speed saturation bounds
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 5'sd8;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = -5'sd8;

   // Characters of interest
   localparam logic [KEY_W-1:0] CH_BEL       = 8'h07;
   localparam logic [KEY_W-1:0] CH_ESC       = 8'h1B;
   localparam logic [KEY_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [KEY_W-1:0] CH_PLUS      = 8'h2B;
   localparam logic [KEY_W-1:0] CH_MINUS     = 8'h2D;
   localparam logic [KEY_W-1:0] CH_DOT       = 8'h2E;
   localparam logic [KEY_W-1:0] CH_ONE       = 8'h31;
   localparam logic [KEY_W-1:0] CH_QUESTION  = 8'h3F;
   localparam logic [KEY_W-1:0] CH_UP_F      = 8'h46;
   localparam logic [KEY_W-1:0] CH_UP_P      = 8'h50;
   localparam logic [KEY_W-1:0] CH_UP_S      = 8'h53;
   localparam logic [KEY_W-1:0] CH_UP_X      = 8'h58;
   localparam logic [KEY_W-1:0] CH_LBRACKET  = 8'h5B;
   localparam logic [KEY_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [KEY_W-1:0] CH_RBRACKET  = 8'h5D;
   localparam logic [KEY_W-1:0] CH_CARET     = 8'h5E;
   localparam logic [KEY_W-1:0] CH_UNDERLINE = 8'h5F;
   localparam logic [KEY_W-1:0] CH_LO_F      = 8'h66;
   localparam logic [KEY_W-1:0] CH_LO_P      = 8'h70;
   localparam logic [KEY_W-1:0] CH_LO_S      = 8'h73;

   // Parser modes
   typedef enum logic [2:0] {
      MODE_PLAIN     = 3'd0,
      MODE_INTRO     = 3'd1,
      MODE_CTRL_SEQ  = 3'd2,
      MODE_STR       = 3'd3,
      MODE_STR_INTRO = 3'd4
   } mode_type;

   // Filter state carried from byte to byte
   typedef struct packed {
      mode_type                    parse_mode;
      logic signed [SPEED_W-1:0]   speed_level;
      logic                        pause_flag;
      logic [COUNT_W-1:0]          kept_count;
   } state_type;

   // One result item
   typedef struct packed {
      logic                        status_changed;
      logic                        skip_wait;
      logic                        paused;
      logic signed [SPEED_W-1:0]   play_speed;
      logic [KEY_W-1:0]            pass_byte;
      logic                        pass_valid;
   } result_type;

endpackage

FILE: rtl/efpk_step.sv
module efpk_step #(
   parameter int BUFFER_LIMIT = efpk_pkg::BUFFER_LIMIT_DEFAULT
) (
   input  logic [efpk_pkg::KEY_W-1:0] key_byte,
   input  logic                       first_of_buffer,
   input  efpk_pkg::state_type        cur_state,
   output efpk_pkg::state_type        nxt_state,
   output efpk_pkg::result_type       result
);
   import efpk_pkg::*;

   mode_type           mode;
   logic [COUNT_W-1:0] count;

   always_comb begin
      // a new buffer restarts the parser and the kept count
      mode  = first_of_buffer ? MODE_PLAIN : cur_state.parse_mode;
      count = first_of_buffer ? '0 : cur_state.kept_count;

      nxt_state            = cur_state;
      nxt_state.parse_mode = mode;
      nxt_state.kept_count = count;
      result               = '0;

      unique case (mode)
         MODE_INTRO: begin
            case (key_byte) inside
               CH_LBRACKET: nxt_state.parse_mode = MODE_CTRL_SEQ;
               CH_UP_P, CH_RBRACKET, CH_UP_X, CH_CARET, CH_UNDERLINE:
                  nxt_state.parse_mode = MODE_STR;
               default: nxt_state.parse_mode = MODE_PLAIN;
            endcase
         end
         MODE_CTRL_SEQ: begin
            // parameter and intermediate bytes keep the sequence open
            if (key_byte < CH_SPACE || key_byte > CH_QUESTION) begin
               nxt_state.parse_mode = MODE_PLAIN;
            end
         end
         MODE_STR: begin
            if (key_byte == CH_ESC) begin
               nxt_state.parse_mode = MODE_STR_INTRO;
            end else if (key_byte == CH_BEL) begin
               nxt_state.parse_mode = MODE_PLAIN;
            end
         end
         MODE_STR_INTRO: begin
            if (key_byte == CH_BACKSLASH) begin
               nxt_state.parse_mode = MODE_PLAIN;
            end else if (key_byte != CH_ESC) begin
               nxt_state.parse_mode = MODE_STR;
            end
         end
         default: begin
            // plain mode; unused codes fall here as well
            nxt_state.parse_mode = MODE_PLAIN;
            case (key_byte) inside
               CH_ONE: begin
                  nxt_state.speed_level = '0;
                  result.status_changed = 1'b1;
               end
               CH_LO_F, CH_UP_F, CH_PLUS: begin
                  if (cur_state.speed_level < SPEED_MAX) begin
                     nxt_state.speed_level = cur_state.speed_level + 5'sd1;
                     result.status_changed = 1'b1;
                  end
               end
               CH_LO_S, CH_UP_S, CH_MINUS: begin
                  if (cur_state.speed_level > SPEED_MIN) begin
                     nxt_state.speed_level = cur_state.speed_level - 5'sd1;
                     result.status_changed = 1'b1;
                  end
               end
               CH_LO_P, CH_UP_P: begin
                  nxt_state.pause_flag  = ~cur_state.pause_flag;
                  result.status_changed = 1'b1;
               end
               CH_SPACE, CH_DOT: result.skip_wait = 1'b1;
               CH_ESC: nxt_state.parse_mode = MODE_INTRO;
               default: begin
                  if (count < COUNT_W'(BUFFER_LIMIT)) begin
                     result.pass_valid    = 1'b1;
                     result.pass_byte     = key_byte;
                     nxt_state.kept_count = count + 1'b1;
                  end
               end
            endcase
         end
      endcase

      result.play_speed = nxt_state.speed_level;
      result.paused     = nxt_state.pause_flag;
   end

endmodule

FILE: rtl/escape_filter_playback_keys_core.sv
// Two register stages: a byte accepted on req_* goes into the input register, is
// filtered into the result register and shown on rsp_*. Throughput: one byte per cycle
// unless rsp_tready stalls; req_tready stays high while the result register drains.
// Reset (synchronous, active high) empties both stages and returns the parser to plain
// mode with speed zero, not paused and a kept count of zero.
module escape_filter_playback_keys_core #(
   parameter int BUFFER_LIMIT = efpk_pkg::BUFFER_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] key_byte
   input  logic [0:0]  req_tuser,   // [0] first_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] pass_valid, [8:1] pass_byte, [13:9] play_speed, [14] paused,
   // [15] skip_wait, [16] status_changed, [23:17] zero
   output logic [23:0] rsp_tdata
);
   import efpk_pkg::*;

   // input stage
   logic               in_valid_ff, in_valid_in;
   logic [KEY_W-1:0]   in_byte_ff, in_byte_in;
   logic               in_first_ff, in_first_in;

   // filter state and result stage
   state_type          state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   state_type          step_state;
   result_type         step_result;
   logic               advance;

   efpk_step #(
      .BUFFER_LIMIT(BUFFER_LIMIT)
   ) u_step (
      .key_byte       (in_byte_ff),
      .first_of_buffer(in_first_ff),
      .cur_state      (state_ff),
      .nxt_state      (step_state),
      .result         (step_result)
   );

   // handshake: input stage moves on whenever the result slot is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_first_in  = in_first_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_first_in = req_tuser[0];
      end

      if (rsp_tvalid && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         state_in     = step_state;
         out_valid_in = 1'b1;
         out_in       = step_result;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{parse_mode: MODE_PLAIN, speed_level: '0,
                           pause_flag: 1'b0, kept_count: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_first_ff <= in_first_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.status_changed, out_ff.skip_wait, out_ff.paused,
                        out_ff.play_speed, out_ff.pass_byte, out_ff.pass_valid};

   // speed stays within its saturation bounds
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.speed_level <= SPEED_MAX && state_ff.speed_level >= SPEED_MIN)
      else $error("speed level out of range");

   // kept count never passes the buffer limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.kept_count <= COUNT_W'(BUFFER_LIMIT))
      else $error("kept count beyond buffer limit");

   // filter state only moves when a byte is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a processed byte");

   // a dropped byte carries a zero payload
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_ff.pass_valid |-> out_ff.pass_byte == '0)
      else $error("dropped byte with nonzero payload");

   // a single byte takes at most one action: playback key, skip request or forward
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones({out_ff.pass_valid, out_ff.skip_wait,
                                 out_ff.status_changed}) <= 1)
      else $error("byte took more than one action");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import efpk_pkg::*;

   // Kept-byte limit of the default build
   localparam int KEEP_LIMIT = BUFFER_LIMIT_DEFAULT;

   // Scoreboard: tracks the filter state and the results still due
   class key_filter_scoreboard;
      mode_type                  mode;
      logic signed [SPEED_W-1:0] speed;
      logic                      paused;
      logic [COUNT_W-1:0]        kept;
      int                        keep_limit;
      result_type                due_results[$];
      int                        errors;

      function new(int limit);
         keep_limit = limit;
         mode       = MODE_PLAIN;
         speed      = '0;
         paused     = 1'b0;
         kept       = '0;
         errors     = 0;
      endfunction

      // Work out the result of one accepted key transaction
      function void accept_key(logic [KEY_W-1:0] key, logic first);
         result_type r;
         r = '0;
         if (first) begin
            mode = MODE_PLAIN;
            kept = '0;
         end
         case (mode)
            MODE_INTRO: begin
               if (key == CH_LBRACKET)
                  mode = MODE_CTRL_SEQ;
               else if (key inside {CH_UP_P, CH_RBRACKET, CH_UP_X, CH_CARET, CH_UNDERLINE})
                  mode = MODE_STR;
               else
                  mode = MODE_PLAIN;
            end
            MODE_CTRL_SEQ: begin
               if (key < CH_SPACE || key > CH_QUESTION)
                  mode = MODE_PLAIN;
            end
            MODE_STR: begin
               if (key == CH_ESC)
                  mode = MODE_STR_INTRO;
               else if (key == CH_BEL)
                  mode = MODE_PLAIN;
            end
            MODE_STR_INTRO: begin
               if (key == CH_BACKSLASH)
                  mode = MODE_PLAIN;
               else if (key != CH_ESC)
                  mode = MODE_STR;
            end
            default: begin
               mode = MODE_PLAIN;
               case (key)
                  CH_ONE: begin
                     speed = '0;
                     r.status_changed = 1'b1;
                  end
                  CH_LO_F, CH_UP_F, CH_PLUS: begin
                     if (speed < SPEED_MAX) begin
                        speed = speed + 5'sd1;
                        r.status_changed = 1'b1;
                     end
                  end
                  CH_LO_S, CH_UP_S, CH_MINUS: begin
                     if (speed > SPEED_MIN) begin
                        speed = speed - 5'sd1;
                        r.status_changed = 1'b1;
                     end
                  end
                  CH_LO_P, CH_UP_P: begin
                     paused = ~paused;
                     r.status_changed = 1'b1;
                  end
                  CH_SPACE, CH_DOT: r.skip_wait = 1'b1;
                  CH_ESC: mode = MODE_INTRO;
                  default: begin
                     // forward until the buffer is full
                     if (kept < keep_limit) begin
                        r.pass_valid = 1'b1;
                        r.pass_byte  = key;
                        kept = kept + 1'b1;
                     end
                  end
               endcase
            end
         endcase
         r.play_speed = speed;
         r.paused     = paused;
         due_results.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compare one result transaction with the oldest one due
      function void check_result(logic [23:0] data);
         result_type want, got;
         if (due_results.size() == 0) begin
            $display("%0t: result with none due, expected nothing, actual %h", $time, data);
            errors++;
            return;
         end
         want = due_results.pop_front();
         got  = data[16:0];
         compare_field("pass_valid", int'(want.pass_valid), int'(got.pass_valid));
         compare_field("pass_byte", int'(want.pass_byte), int'(got.pass_byte));
         compare_field("play_speed", int'(want.play_speed), int'(got.play_speed));
         compare_field("paused", int'(want.paused), int'(got.paused));
         compare_field("skip_wait", int'(want.skip_wait), int'(got.skip_wait));
         compare_field("status_changed", int'(want.status_changed),
                       int'(got.status_changed));
         compare_field("pad bits", 0, int'(data[23:17]));
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] key_byte
   logic [0:0]  req_tuser  = '0;   // [0] first_of_buffer
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] pass_valid, [8:1] pass_byte, [13:9] play_speed, [14] paused,
   // [15] skip_wait, [16] status_changed, [23:17] zero
   logic [23:0] rsp_tdata;

   int send_idle_pct = 24;
   int recv_idle_pct = 78;
   int keys_sent     = 0;

   key_filter_scoreboard sb = new(KEEP_LIMIT);

   // Opening keys: extremes, every playback key, each sequence kind
   logic [7:0] opening_keys[$] = '{
      8'h00, 8'hFF, CH_ONE, CH_LO_F, CH_UP_F, CH_PLUS, CH_LO_S, CH_UP_S, CH_MINUS,
      CH_LO_P, CH_UP_P, CH_SPACE, CH_DOT,
      CH_ESC, CH_LBRACKET, CH_ONE, 8'h68,                  // CSI with a digit inside
      CH_ESC, CH_RBRACKET, CH_BEL,                         // string ended by BEL
      CH_ESC, CH_UP_P, CH_ESC, CH_ESC, CH_BACKSLASH,       // string ended by ESC backslash
      CH_ESC, 8'h63                                        // ESC then another byte
   };

   escape_filter_playback_keys_core #(
      .BUFFER_LIMIT(KEEP_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Result side: check each accepted transaction, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Drive one key transaction, with random idle cycles ahead of it
   task automatic send_key(input logic [7:0] key, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.accept_key(key, first);
      keys_sent++;
   endtask

   // Key with a random buffer start, about one in forty
   task automatic type_key(input logic [7:0] key);
      send_key(key, $urandom_range(39) == 0);
   endtask

   // Hold off the sender until every result due has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.due_results.size() != 0)
         @(posedge clock);
   endtask

   // Mostly well-formed sequences with random content, some noise
   task automatic play_random(input int count);
      int         target, kind, n;
      logic [7:0] b;
      target = keys_sent + count;
      while (keys_sent < target) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            // printable text, playback keys now and then
            repeat ($urandom_range(8, 1)) type_key(8'($urandom_range(8'h7E, 8'h20)));
         end else if (kind < 45) begin
            // speed burst in one direction, sometimes long enough to saturate
            n = $urandom_range(1);
            repeat ($urandom_range(12, 1)) begin
               case ($urandom_range(2))
                  0: b = n ? CH_LO_F : CH_LO_S;
                  1: b = n ? CH_UP_F : CH_UP_S;
                  default: b = n ? CH_PLUS : CH_MINUS;
               endcase
               type_key(b);
            end
            if ($urandom_range(3) == 0)
               type_key(CH_ONE);
         end else if (kind < 55) begin
            case ($urandom_range(4))
               0: type_key(CH_LO_P);
               1: type_key(CH_UP_P);
               2: type_key(CH_SPACE);
               3: type_key(CH_DOT);
               default: type_key(CH_ONE);
            endcase
         end else if (kind < 75) begin
            // CSI: parameter bytes, then any byte outside 0x20..0x3F
            type_key(CH_ESC);
            type_key(CH_LBRACKET);
            repeat ($urandom_range(4)) type_key(8'($urandom_range(8'h3F, 8'h20)));
            b = 8'($urandom_range(255));
            if (b >= CH_SPACE && b <= CH_QUESTION)
               b = b + 8'h40;
            type_key(b);
         end else if (kind < 90) begin
            // string sequence
            type_key(CH_ESC);
            case ($urandom_range(4))
               0: type_key(CH_UP_P);
               1: type_key(CH_RBRACKET);
               2: type_key(CH_UP_X);
               3: type_key(CH_CARET);
               default: type_key(CH_UNDERLINE);
            endcase
            repeat ($urandom_range(6)) begin
               b = 8'($urandom_range(255));
               if ($urandom_range(4) == 0) begin
                  // ESC inside a string that does not end it
                  type_key(CH_ESC);
                  if (b == CH_BACKSLASH)
                     b = 8'h41;
               end else if (b == CH_ESC || b == CH_BEL) begin
                  b = 8'h61;
               end
               type_key(b);
            end
            if ($urandom_range(1)) begin
               type_key(CH_BEL);
            end else begin
               repeat ($urandom_range(3, 1)) type_key(CH_ESC);
               type_key(CH_BACKSLASH);
            end
         end else if (kind < 95) begin
            type_key(CH_ESC);
            type_key(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(6, 1)) type_key(8'($urandom_range(255)));
         end
      end
   endtask

   // Stimulus and end of run
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_keys[i])
         send_key(opening_keys[i], i == 0 || i == 13);
      play_random(275);
      wait_drained();

      send_idle_pct = 78;
      recv_idle_pct = 24;
      play_random(275);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      play_random(275);
      wait_drained();

      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
